// File: rtl/core/tob_pkg.sv
// ----------------------------------------------------------------------------
// Text or binary classifier package
// Beat types, verdict reason codes and default sample length.
// ----------------------------------------------------------------------------
package tob_pkg;

   localparam int DefaultSampleBytes = 2048;

   localparam logic [2:0] ReasonUtf8     = 3'd0;
   localparam logic [2:0] ReasonSjis     = 3'd1;
   localparam logic [2:0] ReasonZero     = 3'd2;
   localparam logic [2:0] ReasonRatioHi  = 3'd3;
   localparam logic [2:0] ReasonRatioLo  = 3'd4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_payload_type;

   typedef struct packed {
      logic       binary_flag;
      logic [2:0] verdict_reason;
   } rsp_payload_type;

   typedef struct packed {
      logic            valid;
      req_payload_type payload;
   } beat_type;

endpackage

// File: rtl/core/tob_input_stage.sv
// ----------------------------------------------------------------------------
// Input register
// Holds one request beat until the classifier stage takes it.
// ----------------------------------------------------------------------------
module tob_input_stage (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  tob_pkg::req_payload_type req_payload,
   output tob_pkg::beat_type        beat,
   input  logic                     advance
);

   logic                     valid_ff;
   logic                     valid_in;
   tob_pkg::req_payload_type payload_ff;

   assign req_ready = !valid_ff || advance;
   assign valid_in  = req_ready ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         payload_ff <= req_payload;
      end
   end

   assign beat.valid   = valid_ff;
   assign beat.payload = payload_ff;

endmodule

// File: rtl/core/tob_sniffer.sv
// ----------------------------------------------------------------------------
// Sniffer stage
// Updates the UTF-8, Shift-JIS, zero and non-printable trackers for each of the
// first SAMPLE_BYTES bytes and registers the verdict on the last byte of a sample.
// ----------------------------------------------------------------------------
module tob_sniffer #(
   parameter int SAMPLE_BYTES = tob_pkg::DefaultSampleBytes
) (
   input  logic                     clock,
   input  logic                     reset,
   input  tob_pkg::beat_type        beat,
   output logic                     advance,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output tob_pkg::rsp_payload_type rsp_payload
);

   localparam int CountWidth = $clog2(SAMPLE_BYTES + 1);
   localparam logic [CountWidth-1:0] Limit = CountWidth'(SAMPLE_BYTES);

   logic [CountWidth-1:0] bytes_seen_ff, bytes_seen_in;
   logic [CountWidth-1:0] nonprint_ff, nonprint_in;
   logic [1:0]            utf8_pending_ff, utf8_pending_in;
   logic                  utf8_failed_ff, utf8_failed_in;
   logic                  sjis_trail_ff, sjis_trail_in;
   logic                  sjis_failed_ff, sjis_failed_in;
   logic                  zero_seen_ff, zero_seen_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   tob_pkg::rsp_payload_type rsp_payload_ff, verdict;

   logic [7:0]            b;
   logic                  take;
   logic [CountWidth+1:0] ratio_lhs, ratio_rhs;

   assign b       = beat.payload.data_byte;
   assign advance = beat.valid && (!beat.payload.last_byte || !rsp_valid_ff || rsp_ready);
   assign take    = bytes_seen_ff < Limit;

   always_comb begin
      bytes_seen_in   = bytes_seen_ff;
      nonprint_in     = nonprint_ff;
      utf8_pending_in = utf8_pending_ff;
      utf8_failed_in  = utf8_failed_ff;
      sjis_trail_in   = sjis_trail_ff;
      sjis_failed_in  = sjis_failed_ff;
      zero_seen_in    = zero_seen_ff;
      if (take) begin
         bytes_seen_in = bytes_seen_ff + CountWidth'(1);
         if (!utf8_failed_ff) begin
            if (utf8_pending_ff != 2'd0) begin
               if (b[7:6] == 2'b10) begin
                  utf8_pending_in = utf8_pending_ff - 2'd1;
               end else begin
                  utf8_failed_in = 1'b1;
               end
            end else if (!b[7]) begin
               utf8_pending_in = 2'd0;
            end else if (b[7:5] == 3'b110) begin
               utf8_pending_in = 2'd1;
            end else if (b[7:4] == 4'b1110) begin
               utf8_pending_in = 2'd2;
            end else if (b[7:3] == 5'b11110) begin
               utf8_pending_in = 2'd3;
            end else begin
               utf8_failed_in = 1'b1;
            end
         end
         if (!sjis_failed_ff) begin
            if (sjis_trail_ff) begin
               if (b inside {[8'h40:8'h7E], [8'h80:8'hFC]}) begin
                  sjis_trail_in = 1'b0;
               end else begin
                  sjis_failed_in = 1'b1;
               end
            end else if (b inside {[8'h00:8'h7F], [8'hA1:8'hDF]}) begin
               sjis_trail_in = 1'b0;
            end else if (b inside {[8'h81:8'h9F], [8'hE0:8'hEF]}) begin
               sjis_trail_in = 1'b1;
            end else begin
               sjis_failed_in = 1'b1;
            end
         end
         if (b == 8'h00) begin
            zero_seen_in = 1'b1;
         end
         if (!(b inside {[8'h20:8'h7E], 8'h09, 8'h0A, 8'h0D})) begin
            nonprint_in = nonprint_ff + CountWidth'(1);
         end
      end
   end

   assign ratio_lhs = {nonprint_in, 2'b00};
   assign ratio_rhs = {2'b00, bytes_seen_in};

   always_comb begin
      if (!utf8_failed_in && utf8_pending_in == 2'd0) begin
         verdict = '{binary_flag: 1'b0, verdict_reason: tob_pkg::ReasonUtf8};
      end else if (!sjis_failed_in && !sjis_trail_in) begin
         verdict = '{binary_flag: 1'b0, verdict_reason: tob_pkg::ReasonSjis};
      end else if (zero_seen_in) begin
         verdict = '{binary_flag: 1'b1, verdict_reason: tob_pkg::ReasonZero};
      end else if (ratio_lhs > ratio_rhs) begin
         verdict = '{binary_flag: 1'b1, verdict_reason: tob_pkg::ReasonRatioHi};
      end else begin
         verdict = '{binary_flag: 1'b0, verdict_reason: tob_pkg::ReasonRatioLo};
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (advance && beat.payload.last_byte) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (advance && beat.payload.last_byte)) begin
         bytes_seen_ff   <= '0;
         nonprint_ff     <= '0;
         utf8_pending_ff <= 2'd0;
         utf8_failed_ff  <= 1'b0;
         sjis_trail_ff   <= 1'b0;
         sjis_failed_ff  <= 1'b0;
         zero_seen_ff    <= 1'b0;
      end else if (advance) begin
         bytes_seen_ff   <= bytes_seen_in;
         nonprint_ff     <= nonprint_in;
         utf8_pending_ff <= utf8_pending_in;
         utf8_failed_ff  <= utf8_failed_in;
         sjis_trail_ff   <= sjis_trail_in;
         sjis_failed_ff  <= sjis_failed_in;
         zero_seen_ff    <= zero_seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && beat.payload.last_byte) begin
         rsp_payload_ff <= verdict;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// File: rtl/core/text_or_binary_classifier.sv
// ----------------------------------------------------------------------------
// Text or binary classifier
// Sniffs a byte sample for UTF-8 or Shift-JIS validity, zero bytes and the
// share of non-printable bytes, and gives one verdict per sample.
// ----------------------------------------------------------------------------
//  channel   ports                     beat
//  request   req_valid/req_ready       one sample byte, last flag
//  response  rsp_valid/rsp_ready       binary flag, reason, on last byte only
//
// One byte per cycle sustained while no verdict is stalled; a verdict leaves
// through the input register, then the result register, once its last byte is taken.
// Synchronous reset clears the trackers and both valid flags.
// A stalled response holds only a last byte; other bytes keep flowing.
module text_or_binary_classifier #(
   parameter int SAMPLE_BYTES = tob_pkg::DefaultSampleBytes
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  tob_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output tob_pkg::rsp_payload_type rsp_payload
);

   tob_pkg::beat_type beat;
   logic              advance;

   tob_input_stage u_input (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .beat        (beat),
      .advance     (advance)
   );

   tob_sniffer #(
      .SAMPLE_BYTES (SAMPLE_BYTES)
   ) u_sniffer (
      .clock       (clock),
      .reset       (reset),
      .beat        (beat),
      .advance     (advance),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
